>>> sv/triangle_plane_setup_defines.svh
// Assertion macros used by the checker of the triangle plane setup block.
`ifndef TRIANGLE_PLANE_SETUP_DEFINES_SVH
`define TRIANGLE_PLANE_SETUP_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted.
`define TPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define TPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

// Condition that holds at every clock edge, reset included.
`define TPS_ASSERT_ALWAYS(label, clk, cond, msg) \
	label: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

>>> sv/tps_pkg.sv
`timescale 1ns / 1ps
package tps_pkg;
	// Default vertex coordinate width and fraction width of the edge planes.
	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 32;
	// Edge plane outputs are signed fixed point of this width.
	localparam int EDGE_BITS = 48;
	// The divider produces one extra quotient bit for rounding.
	localparam int QUOT_BITS = EDGE_BITS + 1;
	// Register stages of the front arithmetic section.
	localparam int FRONT_STAGES = 7;
	// Register stages of one divider lane.
	localparam int LANE_STAGES = QUOT_BITS + 3;
	// Number of edge plane outputs, one divider lane each.
	localparam int NUM_LANES = 8;
endpackage

>>> sv/tps_front.sv
`timescale 1ns / 1ps
module tps_front #(
	parameter int COORD_BITS = 12,
	localparam int NB = 2 * COORD_BITS + 2,
	localparam int OB = 3 * COORD_BITS + 3,
	localparam int LW = 4 * COORD_BITS + 6,
	localparam int NW = 4 * COORD_BITS + 7
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic signed [COORD_BITS-1:0] va [3],
	input  logic signed [COORD_BITS-1:0] vb [3],
	input  logic signed [COORD_BITS-1:0] vc [3],
	output logic                         out_valid,
	output logic signed [NW-1:0]         num [8],
	output logic        [LW-1:0]         len2,
	output logic signed [NB-1:0]         normal [3],
	output logic signed [OB-1:0]         offset
);
	localparam int DB = COORD_BITS + 1;
	localparam int SB = 3 * COORD_BITS + 4;
	localparam int PB = 4 * COORD_BITS + 4;

	logic [6:0] v_s;

	logic signed [COORD_BITS-1:0] a_s1 [3], a_s2 [3], a_s3 [3], a_s4 [3], a_s5 [3];
	logic signed [DB-1:0] ab_s1 [3], ac_s1 [3], ab_s2 [3], ac_s2 [3], ab_s3 [3], ac_s3 [3];
	logic signed [NB-1:0] p_s2 [6];
	logic signed [NB-1:0] n_s3 [3], n_s4 [3], n_s5 [3], n_s6 [3], n_s7 [3];
	logic signed [PB-1:0] sq_s4 [3];
	logic signed [OB-1:0] an_s4 [3], un_s4 [6], vn_s4 [6];
	logic        [LW-1:0] len2_s5, len2_s6, len2_s7;
	logic signed [OB-1:0] d_s5, d_s6, d_s7;
	logic signed [SB-1:0] su_s5 [3], sv_s5 [3], su_s6 [3], sv_s6 [3];
	logic signed [PB-1:0] pu_s6 [3], pv_s6 [3];
	logic signed [NW-1:0] num_s7 [8];

	// Valid bits travel with the data and advance only when the pipeline moves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[5:0], in_valid};
		end
	end

	// Stage 1: edge vectors from vertex A.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				a_s1[k]  <= va[k];
				ab_s1[k] <= DB'(vb[k]) - DB'(va[k]);
				ac_s1[k] <= DB'(vc[k]) - DB'(va[k]);
			end
		end
	end

	// Stage 2: partial products of the normal.
	always_ff @(posedge clk) begin
		if (en) begin
			p_s2[0] <= ab_s1[1] * ac_s1[2];
			p_s2[1] <= ab_s1[2] * ac_s1[1];
			p_s2[2] <= ab_s1[2] * ac_s1[0];
			p_s2[3] <= ab_s1[0] * ac_s1[2];
			p_s2[4] <= ab_s1[0] * ac_s1[1];
			p_s2[5] <= ab_s1[1] * ac_s1[0];
			a_s2  <= a_s1;
			ab_s2 <= ab_s1;
			ac_s2 <= ac_s1;
		end
	end

	// Stage 3: the normal itself.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				n_s3[k] <= p_s2[2 * k] - p_s2[2 * k + 1];
			end
			a_s3  <= a_s2;
			ab_s3 <= ab_s2;
			ac_s3 <= ac_s2;
		end
	end

	// Stage 4: squares, offset terms and the products of both edge cross products.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				sq_s4[k] <= n_s3[k] * n_s3[k];
				an_s4[k] <= OB'(a_s3[k] * n_s3[k]);
			end
			un_s4[0] <= ac_s3[1] * n_s3[2];
			un_s4[1] <= ac_s3[2] * n_s3[1];
			un_s4[2] <= ac_s3[2] * n_s3[0];
			un_s4[3] <= ac_s3[0] * n_s3[2];
			un_s4[4] <= ac_s3[0] * n_s3[1];
			un_s4[5] <= ac_s3[1] * n_s3[0];
			vn_s4[0] <= n_s3[1] * ab_s3[2];
			vn_s4[1] <= n_s3[2] * ab_s3[1];
			vn_s4[2] <= n_s3[2] * ab_s3[0];
			vn_s4[3] <= n_s3[0] * ab_s3[2];
			vn_s4[4] <= n_s3[0] * ab_s3[1];
			vn_s4[5] <= n_s3[1] * ab_s3[0];
			a_s4 <= a_s3;
			n_s4 <= n_s3;
		end
	end

	// Stage 5: squared length, plane offset and the edge numerators.
	always_ff @(posedge clk) begin
		if (en) begin
			len2_s5 <= LW'($unsigned(sq_s4[0])) + LW'($unsigned(sq_s4[1]))
				+ LW'($unsigned(sq_s4[2]));
			d_s5 <= an_s4[0] + an_s4[1] + an_s4[2];
			for (int k = 0; k < 3; k++) begin
				su_s5[k] <= SB'(un_s4[2 * k]) - SB'(un_s4[2 * k + 1]);
				sv_s5[k] <= SB'(vn_s4[2 * k]) - SB'(vn_s4[2 * k + 1]);
			end
			a_s5 <= a_s4;
			n_s5 <= n_s4;
		end
	end

	// Stage 6: products of the edge numerators with vertex A.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				pu_s6[k] <= su_s5[k] * a_s5[k];
				pv_s6[k] <= sv_s5[k] * a_s5[k];
			end
			su_s6   <= su_s5;
			sv_s6   <= sv_s5;
			len2_s6 <= len2_s5;
			d_s6    <= d_s5;
			n_s6    <= n_s5;
		end
	end

	// Stage 7: negated edge offsets; all eight numerators line up here.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				num_s7[k]     <= NW'(su_s6[k]);
				num_s7[4 + k] <= NW'(sv_s6[k]);
			end
			num_s7[3] <= -(NW'(pu_s6[0]) + NW'(pu_s6[1]) + NW'(pu_s6[2]));
			num_s7[7] <= -(NW'(pv_s6[0]) + NW'(pv_s6[1]) + NW'(pv_s6[2]));
			len2_s7 <= len2_s6;
			d_s7    <= d_s6;
			n_s7    <= n_s6;
		end
	end

	assign out_valid = v_s[6];
	assign num       = num_s7;
	assign len2      = len2_s7;
	assign normal    = n_s7;
	assign offset    = d_s7;
endmodule

>>> sv/tps_div_lane.sv
`timescale 1ns / 1ps
module tps_div_lane #(
	parameter int NUM_W     = 55,
	parameter int DEN_W     = 54,
	parameter int FRAC_BITS = 32
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [NUM_W-1:0]          num,
	input  logic        [DEN_W-1:0]          den [tps_pkg::QUOT_BITS+1],
	output logic        [tps_pkg::EDGE_BITS-1:0] result
);
	import tps_pkg::*;

	localparam int QB = QUOT_BITS;
	localparam int DW = (NUM_W + FRAC_BITS + 1 > QB + 1) ? NUM_W + FRAC_BITS + 1 : QB + 1;
	localparam int HW = DW - QB;
	localparam int CW = (HW > DEN_W + 1) ? HW : DEN_W + 1;

	logic             neg_s1;
	logic [NUM_W-1:0] mag_s1;

	logic [DEN_W-1:0] rem_s  [QB+1];
	logic [QB-1:0]    lowq_s [QB+1];
	logic             neg_s  [QB+1];
	logic             ovf_s  [QB+1];

	logic [DW-1:0]    dvd;
	logic [HW-1:0]    dvd_hi;

	logic [QB:0]      rnd;
	logic [QB-1:0]    qr, lim, qm, qs;
	logic             sat;
	logic [EDGE_BITS-1:0] res_so;

	// Stage A: sign and magnitude of the numerator.
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= num[NUM_W-1];
			mag_s1 <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
		end
	end

	// Stage B: scale the magnitude, split off the high part and test for overflow.
	always_comb begin
		dvd    = DW'(mag_s1) << (FRAC_BITS + 1);
		dvd_hi = dvd[DW-1:QB];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0]  <= CW'(dvd_hi) >= CW'(den[0]);
			rem_s[0]  <= DEN_W'(dvd_hi);
			lowq_s[0] <= dvd[QB-1:0];
			neg_s[0]  <= neg_s1;
		end
	end

	// One restoring division step per stage; dividend bits shift out the top of
	// lowq while quotient bits shift in at the bottom.
	for (genvar i = 0; i < QB; i++) begin : g_step
		logic [DEN_W:0] trial, diff;
		logic           ge;

		always_comb begin
			trial = {rem_s[i], lowq_s[i][QB-1]};
			diff  = trial - {1'b0, den[i+1]};
			ge    = trial >= {1'b0, den[i+1]};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				lowq_s[i+1] <= {lowq_s[i][QB-2:0], ge};
				neg_s[i+1]  <= neg_s[i];
				ovf_s[i+1]  <= ovf_s[i];
			end
		end
	end

	// Final stage: round half away from zero, saturate and restore the sign.
	always_comb begin
		rnd = (QB + 1)'(lowq_s[QB]) + (QB + 1)'(1);
		qr  = rnd[QB:1];
		lim = neg_s[QB] ? (QB'(1) << (EDGE_BITS - 1)) : ((QB'(1) << (EDGE_BITS - 1)) - QB'(1));
		sat = ovf_s[QB] || (qr > lim);
		qm  = sat ? lim : qr;
		qs  = neg_s[QB] ? -qm : qm;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_so <= qs[EDGE_BITS-1:0];
		end
	end

	assign result = res_so;
endmodule

>>> sv/triangle_plane_setup.sv
`timescale 1ns / 1ps
// Triangle plane setup for ray/triangle intersection.
// Input channel: one triangle per transaction on tri_valid/tri_stall, vertices A, B, C
// as signed integer coordinates. Output channel: one setup transaction per triangle
// on setup_valid/setup_stall with the normal, the plane offset and both scaled edge
// planes (signed fixed point, FRAC_BITS fraction bits, saturated; all zero for a
// triangle of zero area).
// The pipeline has seven stages of multiply and add, then eight parallel divider
// lanes that retire one quotient bit per stage plus sign, scale and rounding stages.
// Throughput is one triangle per cycle while the receiver does not stall; every stage
// is a register and no unit is shared between transactions.
// Reset clears all valid bits, so the pipeline comes up empty and ready.
// When the receiver stalls a waiting result, the whole pipeline holds in place and
// tri_stall rises in the same cycle; nothing is lost or repeated, and the result
// on the output ports stays unchanged until it is taken.
module triangle_plane_setup #(
	parameter int COORD_BITS = tps_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = tps_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               tri_valid,
	output logic                               tri_stall,
	input  logic signed [COORD_BITS-1:0]       vertex_a_x,
	input  logic signed [COORD_BITS-1:0]       vertex_a_y,
	input  logic signed [COORD_BITS-1:0]       vertex_a_z,
	input  logic signed [COORD_BITS-1:0]       vertex_b_x,
	input  logic signed [COORD_BITS-1:0]       vertex_b_y,
	input  logic signed [COORD_BITS-1:0]       vertex_b_z,
	input  logic signed [COORD_BITS-1:0]       vertex_c_x,
	input  logic signed [COORD_BITS-1:0]       vertex_c_y,
	input  logic signed [COORD_BITS-1:0]       vertex_c_z,
	output logic                               setup_valid,
	input  logic                               setup_stall,
	output logic signed [2*COORD_BITS+1:0]     normal_x,
	output logic signed [2*COORD_BITS+1:0]     normal_y,
	output logic signed [2*COORD_BITS+1:0]     normal_z,
	output logic signed [3*COORD_BITS+2:0]     plane_offset,
	output logic signed [tps_pkg::EDGE_BITS-1:0] edge_u_x,
	output logic signed [tps_pkg::EDGE_BITS-1:0] edge_u_y,
	output logic signed [tps_pkg::EDGE_BITS-1:0] edge_u_z,
	output logic signed [tps_pkg::EDGE_BITS-1:0] edge_u_offset,
	output logic signed [tps_pkg::EDGE_BITS-1:0] edge_v_x,
	output logic signed [tps_pkg::EDGE_BITS-1:0] edge_v_y,
	output logic signed [tps_pkg::EDGE_BITS-1:0] edge_v_z,
	output logic signed [tps_pkg::EDGE_BITS-1:0] edge_v_offset
);
	import tps_pkg::*;

	localparam int NB  = 2 * COORD_BITS + 2;
	localparam int OB  = 3 * COORD_BITS + 3;
	localparam int LW  = 4 * COORD_BITS + 6;
	localparam int NW  = 4 * COORD_BITS + 7;
	localparam int LAT = LANE_STAGES;

	logic en;

	logic signed [COORD_BITS-1:0] va [3], vb [3], vc [3];
	logic                 f_valid;
	logic signed [NW-1:0] f_num [8];
	logic        [LW-1:0] f_len2;
	logic signed [NB-1:0] f_normal [3];
	logic signed [OB-1:0] f_offset;

	logic [LW-1:0]        den_q    [QUOT_BITS+1];
	logic [LAT-1:0]       vld_q;
	logic [LAT-1:0]       zero_q;
	logic signed [NB-1:0] nrm_q    [LAT][3];
	logic signed [OB-1:0] ofs_q    [LAT];
	logic [EDGE_BITS-1:0] lane_res [NUM_LANES];

	// The pipeline advances unless a finished transaction is held by the receiver.
	assign en        = !(setup_valid && setup_stall);
	assign tri_stall = !en;

	assign va = '{vertex_a_x, vertex_a_y, vertex_a_z};
	assign vb = '{vertex_b_x, vertex_b_y, vertex_b_z};
	assign vc = '{vertex_c_x, vertex_c_y, vertex_c_z};

	tps_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (tri_valid),
		.va       (va),
		.vb       (vb),
		.vc       (vc),
		.out_valid(f_valid),
		.num      (f_num),
		.len2     (f_len2),
		.normal   (f_normal),
		.offset   (f_offset)
	);

	// Divisor delay line shared by all lanes, one tap per division step plus one for the overflow test.
	always_ff @(posedge clk) begin
		if (en) begin
			den_q[0] <= f_len2;
			for (int k = 1; k <= QUOT_BITS; k++) begin
				den_q[k] <= den_q[k-1];
			end
		end
	end

	// Valid bits alongside the divider lanes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], f_valid};
		end
	end

	// Normal, offset and the zero-area flag ride along with the divisions.
	always_ff @(posedge clk) begin
		if (en) begin
			zero_q   <= {zero_q[LAT-2:0], (f_len2 == '0)};
			nrm_q[0] <= f_normal;
			ofs_q[0] <= f_offset;
			for (int k = 1; k < LAT; k++) begin
				nrm_q[k] <= nrm_q[k-1];
				ofs_q[k] <= ofs_q[k-1];
			end
		end
	end

	// One divider lane per edge plane output.
	for (genvar j = 0; j < NUM_LANES; j++) begin : g_lane
		tps_div_lane #(
			.NUM_W    (NW),
			.DEN_W    (LW),
			.FRAC_BITS(FRAC_BITS)
		) u_lane (
			.clk   (clk),
			.en    (en),
			.num   (f_num[j]),
			.den   (den_q),
			.result(lane_res[j])
		);
	end

	// Output transaction; a zero-area triangle forces all edge values to zero.
	assign setup_valid   = vld_q[LAT-1];
	assign normal_x      = nrm_q[LAT-1][0];
	assign normal_y      = nrm_q[LAT-1][1];
	assign normal_z      = nrm_q[LAT-1][2];
	assign plane_offset  = ofs_q[LAT-1];
	assign edge_u_x      = zero_q[LAT-1] ? '0 : lane_res[0];
	assign edge_u_y      = zero_q[LAT-1] ? '0 : lane_res[1];
	assign edge_u_z      = zero_q[LAT-1] ? '0 : lane_res[2];
	assign edge_u_offset = zero_q[LAT-1] ? '0 : lane_res[3];
	assign edge_v_x      = zero_q[LAT-1] ? '0 : lane_res[4];
	assign edge_v_y      = zero_q[LAT-1] ? '0 : lane_res[5];
	assign edge_v_z      = zero_q[LAT-1] ? '0 : lane_res[6];
	assign edge_v_offset = zero_q[LAT-1] ? '0 : lane_res[7];
endmodule

>>> sv/tps_checker.sv
`timescale 1ns / 1ps
`include "triangle_plane_setup_defines.svh"
module tps_checker #(
	parameter int COORD_BITS = tps_pkg::COORD_BITS_DEF
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                tri_stall,
	input logic                                setup_valid,
	input logic                                setup_stall,
	input logic signed [2*COORD_BITS+1:0]      normal_x,
	input logic signed [2*COORD_BITS+1:0]      normal_y,
	input logic signed [2*COORD_BITS+1:0]      normal_z,
	input logic signed [tps_pkg::EDGE_BITS-1:0] edge_u_x,
	input logic signed [tps_pkg::EDGE_BITS-1:0] edge_u_y,
	input logic signed [tps_pkg::EDGE_BITS-1:0] edge_u_z,
	input logic signed [tps_pkg::EDGE_BITS-1:0] edge_u_offset,
	input logic signed [tps_pkg::EDGE_BITS-1:0] edge_v_x,
	input logic signed [tps_pkg::EDGE_BITS-1:0] edge_v_y,
	input logic signed [tps_pkg::EDGE_BITS-1:0] edge_v_z,
	input logic signed [tps_pkg::EDGE_BITS-1:0] edge_v_offset
);
	// A held output transaction stays valid, and its normal_x, edge_u_x and edge_v_offset stay unchanged.
	`TPS_ASSERT_NEXT(a_out_hold, clk, arst_n, setup_valid && setup_stall, setup_valid && $stable(normal_x) && $stable(edge_u_x) && $stable(edge_v_offset), "output changed while stalled")

	// The input side only stalls behind a held output transaction.
	`TPS_ASSERT_IMPLY(a_in_stall, clk, arst_n, tri_stall, setup_valid && setup_stall, "input stalled without an output stall")

	// A zero normal means a flat triangle, whose edge planes are all zero.
	`TPS_ASSERT_IMPLY(a_flat_zero, clk, arst_n, setup_valid && normal_x == 0 && normal_y == 0 && normal_z == 0, edge_u_x == 0 && edge_u_y == 0 && edge_u_z == 0 && edge_u_offset == 0 && edge_v_x == 0 && edge_v_y == 0 && edge_v_z == 0 && edge_v_offset == 0, "flat triangle gave nonzero edge plane")

	// No output transaction is offered while reset is asserted.
	`TPS_ASSERT_ALWAYS(a_reset_idle, clk, arst_n || !setup_valid, "output valid during reset")
endmodule

bind triangle_plane_setup tps_checker #(.COORD_BITS(COORD_BITS)) u_tps_checker (.*);
